@@ rtl/qmm_pkg.sv @@
// shared types, widths and register codes of the quad motor mixer
`timescale 1ns / 1ps

package qmm_pkg;

	// sizes
	localparam int NUM_MOTORS = 4;
	localparam int MAX_MOTORS = 4;
	localparam int NUM_AXES   = 4;

	// field widths
	localparam int CMD_W     = 16;
	localparam int MIX_W     = 64;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 2 * CMD_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int MAG_W     = SUM_W - 1;
	localparam int RNG_W     = SUM_W;
	localparam int FRAC_SH   = 14;
	localparam int QUO_W     = 16;
	localparam int NUM_W     = MAG_W + FRAC_SH;
	localparam int CMP_W     = RNG_W + QUO_W;

	// 1.0 at 28 fraction bits
	localparam logic [RNG_W-1:0] RANGE_ONE = RNG_W'(64'd1 << 28);

	// pipeline stage numbers
	localparam int STG_PROD   = 1;
	localparam int STG_SUM    = 2;
	localparam int STG_PAIR   = 3;
	localparam int STG_MINMAX = 4;
	localparam int STG_PREP   = 5;
	localparam int STG_OVF    = 6;
	localparam int STG_OUT    = STG_OVF + QUO_W + 1;
	localparam int NUM_STG    = STG_OUT;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTOR_COUNT = 3'd0,
		REG_MIX_MOTOR0  = 3'd1,
		REG_MIX_MOTOR1  = 3'd2,
		REG_MIX_MOTOR2  = 3'd3,
		REG_MIX_MOTOR3  = 3'd4
	} cfg_reg_t;

	typedef logic [MIX_W-1:0] mix_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// one motor entering the divider
	typedef struct packed {
		logic             act;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} lane_t;

	// one motor leaving the divider
	typedef struct packed {
		logic             act;
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_res_t;

endpackage

@@ rtl/qmm_mac.sv @@
// products and per-motor dot product sums, two pipeline stages
`timescale 1ns / 1ps

module qmm_mac (
	input  logic                               clk,
	input  logic [1:0]                         en,
	input  logic signed [qmm_pkg::CMD_W-1:0]   cmd [qmm_pkg::NUM_AXES],
	input  qmm_pkg::mix_t                      mix [qmm_pkg::NUM_MOTORS],
	output qmm_pkg::sum_t                      sum_s2 [qmm_pkg::NUM_MOTORS]
);
	import qmm_pkg::*;

	prod_t prod_s1 [NUM_MOTORS][NUM_AXES];

	// one multiplier per motor and axis
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_s1[m][a] <= PROD_W'(cmd[a])
						* PROD_W'($signed(mix[m][a*CMD_W +: CMD_W]));
				end
			end
		end
	end

	// add the four axis products of each motor
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				sum_s2[m] <= SUM_W'(prod_s1[m][0]) + SUM_W'(prod_s1[m][1])
					+ SUM_W'(prod_s1[m][2]) + SUM_W'(prod_s1[m][3]);
			end
		end
	end

endmodule

@@ rtl/qmm_range.sv @@
// min and max over the active motors, range and magnitudes, three stages
`timescale 1ns / 1ps

module qmm_range (
	input  logic                          clk,
	input  logic [2:0]                    en,
	input  logic [qmm_pkg::CNT_W-1:0]     motor_count,
	input  qmm_pkg::sum_t                 sum_s2 [qmm_pkg::NUM_MOTORS],
	output qmm_pkg::lane_t                lane_s5 [qmm_pkg::NUM_MOTORS],
	output logic [qmm_pkg::RNG_W-1:0]     range_s5
);
	import qmm_pkg::*;

	logic [CNT_W-1:0]      act_cnt;
	logic [NUM_MOTORS-1:0] act_mask;
	logic [NUM_MOTORS-1:0] act_s3;
	logic [NUM_MOTORS-1:0] act_s4;
	sum_t                  sum_s3 [NUM_MOTORS];
	sum_t                  sum_s4 [NUM_MOTORS];
	sum_t                  lo_pair_s3 [2];
	sum_t                  hi_pair_s3 [2];
	sum_t                  lo_s4;
	sum_t                  hi_s4;
	logic [RNG_W:0]        spread;

	// active motors form a prefix, count clamped to the motor limit
	always_comb begin
		act_cnt = (motor_count > CNT_W'(MAX_MOTORS)) ? CNT_W'(MAX_MOTORS) : motor_count;
		for (int m = 0; m < NUM_MOTORS; m++) begin
			act_mask[m] = CNT_W'(m) < act_cnt;
		end
	end

	// pairwise min and max, motors 0/1 and 2/3
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int p = 0; p < 2; p++) begin
				lo_pair_s3[p] <= (act_mask[2*p+1] && sum_s2[2*p+1] < sum_s2[2*p])
					? sum_s2[2*p+1] : sum_s2[2*p];
				hi_pair_s3[p] <= (act_mask[2*p+1] && sum_s2[2*p+1] > sum_s2[2*p])
					? sum_s2[2*p+1] : sum_s2[2*p];
			end
			sum_s3 <= sum_s2;
			act_s3 <= act_mask;
		end
	end

	// merge the pairs, second pair counts only when motor 2 is active
	always_ff @(posedge clk) begin
		if (en[1]) begin
			lo_s4 <= (act_s3[2] && lo_pair_s3[1] < lo_pair_s3[0]) ? lo_pair_s3[1] : lo_pair_s3[0];
			hi_s4 <= (act_s3[2] && hi_pair_s3[1] > hi_pair_s3[0]) ? hi_pair_s3[1] : hi_pair_s3[0];
			sum_s4 <= sum_s3;
			act_s4 <= act_s3;
		end
	end

	// spread is never negative since hi is at least lo
	assign spread = (RNG_W+1)'(hi_s4) - (RNG_W+1)'(lo_s4);

	// range floor at 1.0, split sums into sign and magnitude
	always_ff @(posedge clk) begin
		if (en[2]) begin
			range_s5 <= (spread < (RNG_W+1)'(RANGE_ONE)) ? RANGE_ONE : spread[RNG_W-1:0];
			for (int m = 0; m < NUM_MOTORS; m++) begin
				lane_s5[m].act <= act_s4[m];
				lane_s5[m].neg <= sum_s4[m][SUM_W-1];
				lane_s5[m].mag <= sum_s4[m][SUM_W-1] ? MAG_W'(-sum_s4[m]) : MAG_W'(sum_s4[m]);
			end
		end
	end

endmodule

@@ rtl/qmm_div_lane.sv @@
// pipelined restoring divider for one motor, one quotient bit per stage
`timescale 1ns / 1ps

module qmm_div_lane (
	input  logic                          clk,
	input  logic [qmm_pkg::QUO_W:0]       en,
	input  qmm_pkg::lane_t                lane,
	input  logic [qmm_pkg::RNG_W-1:0]     range,
	output qmm_pkg::div_res_t             res
);
	import qmm_pkg::*;

	logic [NUM_W-1:0] rem_sd [QUO_W+1];
	logic [RNG_W-1:0] rng_sd [QUO_W+1];
	logic [QUO_W-1:0] quo_sd [QUO_W+1];
	logic             act_sd [QUO_W+1];
	logic             neg_sd [QUO_W+1];
	logic             ovf_sd [QUO_W+1];

	// quotient of 2^16 or more saturates, checked up front
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_sd[0] <= {4'b0000, lane.mag} >= {1'b0, range, 2'b00};
			rem_sd[0] <= {lane.mag, FRAC_SH'(0)};
			rng_sd[0] <= range;
			quo_sd[0] <= '0;
			act_sd[0] <= lane.act;
			neg_sd[0] <= lane.neg;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUO_W; k++) begin : g_bit
		localparam int J = QUO_W - 1 - k;
		logic [CMP_W-1:0] trial;
		logic [CMP_W-1:0] diff;
		logic             ge;

		assign trial = CMP_W'(rng_sd[k]) << J;
		assign ge    = CMP_W'(rem_sd[k]) >= trial;
		assign diff  = CMP_W'(rem_sd[k]) - trial;

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				rem_sd[k+1] <= ge ? diff[NUM_W-1:0] : rem_sd[k];
				quo_sd[k+1] <= quo_sd[k] | (QUO_W'(ge) << J);
				rng_sd[k+1] <= rng_sd[k];
				act_sd[k+1] <= act_sd[k];
				neg_sd[k+1] <= neg_sd[k];
				ovf_sd[k+1] <= ovf_sd[k];
			end
		end
	end

	assign res.act = act_sd[QUO_W];
	assign res.neg = neg_sd[QUO_W];
	assign res.ovf = ovf_sd[QUO_W];
	assign res.quo = quo_sd[QUO_W];

endmodule

@@ rtl/quad_motor_mixer.sv @@
// quad motor mixer top level: config registers, pipeline control, output stage
//
//  channel   signals                                   direction
//  in        in_valid, in_stall, roll/pitch/yaw/throttle_cmd   upstream drives valid
//  out       out_valid, out_stall, drive0..drive3      downstream drives stall
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data write only, always ready
//
// 23 register stages: multiply, add, pair min/max, min/max, range, overflow
// check, 16 divider bit stages, output saturation.
// the divider stages set the depth; one transaction can enter every cycle unless
// in_stall is high. each stage moves when its successor is empty or moving, so
// bubbles close up and input is taken while a result waits at the output.
// arst_n clears the valid bits and loads the default mix and motor count.
`timescale 1ns / 1ps

module quad_motor_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [qmm_pkg::CMD_W-1:0]    roll_cmd,
	input  logic signed [qmm_pkg::CMD_W-1:0]    pitch_cmd,
	input  logic signed [qmm_pkg::CMD_W-1:0]    yaw_cmd,
	input  logic signed [qmm_pkg::CMD_W-1:0]    throttle_cmd,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [qmm_pkg::QUO_W-1:0]    drive0,
	output logic signed [qmm_pkg::QUO_W-1:0]    drive1,
	output logic signed [qmm_pkg::QUO_W-1:0]    drive2,
	output logic signed [qmm_pkg::QUO_W-1:0]    drive3,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qmm_pkg::MIX_W-1:0]           cfg_data
);
	import qmm_pkg::*;

	localparam logic signed [QUO_W-1:0] DRIVE_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic signed [QUO_W-1:0] DRIVE_MIN = {1'b1, {(QUO_W-1){1'b0}}};
	localparam logic [QUO_W-1:0]        NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

	logic [CNT_W-1:0]           motor_count_q;
	mix_t                       mix_q [NUM_MOTORS];
	logic [NUM_STG:1]           vld_q;
	logic [NUM_STG:1]           vld_in;
	logic [NUM_STG+1:1]         ready;
	logic signed [CMD_W-1:0]    cmd [NUM_AXES];
	sum_t                       sum_s2 [NUM_MOTORS];
	lane_t                      lane_s5 [NUM_MOTORS];
	logic [RNG_W-1:0]           range_s5;
	div_res_t                   res [NUM_MOTORS];
	logic signed [QUO_W-1:0]    drive_nxt [NUM_MOTORS];
	logic signed [QUO_W-1:0]    drive_s23 [NUM_MOTORS];

	// configuration writes, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_count_q <= CNT_W'(4);
			mix_q[0]      <= 64'h4000C0004000C000;
			mix_q[1]      <= 64'h40004000C000C000;
			mix_q[2]      <= 64'h4000400040004000;
			mix_q[3]      <= 64'h4000C000C0004000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOTOR_COUNT: motor_count_q <= cfg_data[CNT_W-1:0];
				REG_MIX_MOTOR0:  mix_q[0] <= cfg_data;
				REG_MIX_MOTOR1:  mix_q[1] <= cfg_data;
				REG_MIX_MOTOR2:  mix_q[2] <= cfg_data;
				REG_MIX_MOTOR3:  mix_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage ready chain, a stage moves when it is empty or its successor moves
	assign ready[NUM_STG+1] = !out_stall;
	for (genvar i = 1; i <= NUM_STG; i++) begin : g_ready
		assign ready[i] = !vld_q[i] || ready[i+1];
	end

	assign vld_in   = {vld_q[NUM_STG-1:1], in_valid};
	assign in_stall = !ready[1];
	assign out_valid = vld_q[NUM_STG];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NUM_STG; i++) begin
				if (ready[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// command vector in axis order
	assign cmd[0] = roll_cmd;
	assign cmd[1] = pitch_cmd;
	assign cmd[2] = yaw_cmd;
	assign cmd[3] = throttle_cmd;

	qmm_mac u_mac (
		.clk    (clk),
		.en     (ready[STG_SUM:STG_PROD]),
		.cmd    (cmd),
		.mix    (mix_q),
		.sum_s2 (sum_s2)
	);

	qmm_range u_range (
		.clk         (clk),
		.en          (ready[STG_PREP:STG_PAIR]),
		.motor_count (motor_count_q),
		.sum_s2      (sum_s2),
		.lane_s5     (lane_s5),
		.range_s5    (range_s5)
	);

	for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
		qmm_div_lane u_div (
			.clk   (clk),
			.en    (ready[STG_OUT-1:STG_OVF]),
			.lane  (lane_s5[m]),
			.range (range_s5),
			.res   (res[m])
		);
	end

	// sign, saturation and inactive motors
	always_comb begin
		for (int m = 0; m < NUM_MOTORS; m++) begin
			if (!res[m].act) begin
				drive_nxt[m] = '0;
			end else if (res[m].neg) begin
				drive_nxt[m] = (res[m].ovf || res[m].quo > NEG_LIMIT) ? DRIVE_MIN
					: -$signed(res[m].quo);
			end else begin
				drive_nxt[m] = (res[m].ovf || res[m].quo[QUO_W-1]) ? DRIVE_MAX
					: $signed(res[m].quo);
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ready[STG_OUT]) begin
			drive_s23 <= drive_nxt;
		end
	end

	assign drive0 = drive_s23[0];
	assign drive1 = drive_s23[1];
	assign drive2 = drive_s23[2];
	assign drive3 = drive_s23[3];

`ifndef NO_ASSERTIONS
	// input is held back only while the first stage is occupied
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[STG_PROD])
		else $error("input stalled with first stage empty");

	// occupancy changes by at most one transaction per cycle
	a_occupancy_step: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) <= $countones($past(vld_q)) + 1) &&
		($countones(vld_q) + 1 >= $countones($past(vld_q))))
		else $error("pipeline occupancy jumped");

	// a result appears only after the last divider stage held one
	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_q[STG_OUT-1]))
		else $error("result without divider transaction");
`endif

endmodule
